### rtl/w8u16_pkg.sv
package w8u16_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int ACC_W  = 21;

    localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hF4;
    localparam logic [BYTE_W-1:0] CONT_LO   = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_HI   = 8'hBF;
    localparam logic [BYTE_W-1:0] E0_LO     = 8'hA0;
    localparam logic [BYTE_W-1:0] F0_LO     = 8'h90;
    localparam logic [BYTE_W-1:0] F4_HI     = 8'h8F;

    localparam logic [UNIT_W-1:0] REPL_UNIT = 16'hFFFD;
    localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;
    localparam logic [ACC_W-1:0]  CP_BMP_END = 21'h010000;
    localparam logic [ACC_W-1:0]  CP_MAX     = 21'h10FFFF;

    // units produced by one byte, handed to the output buffer
    typedef struct packed {
        logic              load;
        logic [1:0]        count;
        logic [UNIT_W-1:0] unit0;
        logic [UNIT_W-1:0] unit1;
    } t_unit_load;

endpackage

### rtl/w8u16_in_if.sv
interface w8u16_in_if
    import w8u16_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;

    modport source(output valid, output data_byte, output end_of_string, input ready);
    modport sink(input valid, input data_byte, input end_of_string, output ready);
endinterface

### rtl/w8u16_out_if.sv
interface w8u16_out_if
    import w8u16_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;
    logic              last_of_run;

    modport source(output valid, output code_unit, output last_of_run, input ready);
    modport sink(input valid, input code_unit, input last_of_run, output ready);
endinterface

### rtl/w8u16_in_stage.sv
module w8u16_in_stage
    import w8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    w8u16_in_if.sink          i_in,
    input  logic              i_take,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_eos
);
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_eos;
    logic              accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_in.data_byte;
            r_eos  <= i_in.end_of_string;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eos   = r_eos;
endmodule

### rtl/w8u16_decode.sv
module w8u16_decode
    import w8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_eos,
    input  logic              i_space,
    output logic              o_take,
    output t_unit_load        o_units
);
    logic [1:0]        r_rem, n_rem;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [BYTE_W-1:0] r_lo, n_lo;
    logic [BYTE_W-1:0] r_hi, n_hi;

    logic [1:0]        cnt;
    logic [UNIT_W-1:0] u0, u1;
    logic              do_lead;
    logic [ACC_W-1:0]  cp;
    logic [ACC_W-1:0]  v;

    always_comb begin
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_lo    = r_lo;
        n_hi    = r_hi;
        cnt     = 2'd0;
        u0      = REPL_UNIT;
        u1      = REPL_UNIT;
        do_lead = 1'b0;
        cp      = {r_acc[ACC_W-7:0], i_byte[5:0]};
        v       = cp - CP_BMP_END;

        if (r_rem != 2'd0) begin
            if (i_byte >= r_lo && i_byte <= r_hi) begin
                n_acc = cp;
                n_rem = r_rem - 2'd1;
                n_lo  = CONT_LO;
                n_hi  = CONT_HI;
                if (n_rem == 2'd0) begin
                    n_acc = '0;
                    if (cp < CP_BMP_END) begin
                        u0  = cp[UNIT_W-1:0];
                        cnt = 2'd1;
                    end else if (cp > CP_MAX) begin
                        cnt = 2'd1;
                    end else begin
                        u0  = HI_SURR + {6'd0, v[19:10]};
                        u1  = LO_SURR + {6'd0, v[9:0]};
                        cnt = 2'd2;
                    end
                end
            end else begin
                // close the broken sequence, then retry this byte as a lead
                cnt     = 2'd1;
                do_lead = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        if (do_lead) begin
            n_lo  = CONT_LO;
            n_hi  = CONT_HI;
            n_rem = 2'd0;
            n_acc = '0;
            if (i_byte >= LEAD2_LO && i_byte <= LEAD2_HI) begin
                n_rem = 2'd1;
                n_acc = {16'd0, i_byte[4:0]};
            end else if (i_byte >= LEAD3_LO && i_byte <= LEAD3_HI) begin
                n_rem = 2'd2;
                n_acc = {17'd0, i_byte[3:0]};
                if (i_byte == LEAD3_LO) begin
                    n_lo = E0_LO;
                end
            end else if (i_byte >= LEAD4_LO && i_byte <= LEAD4_HI) begin
                n_rem = 2'd3;
                n_acc = {18'd0, i_byte[2:0]};
                if (i_byte == LEAD4_LO) begin
                    n_lo = F0_LO;
                end else if (i_byte == LEAD4_HI) begin
                    n_hi = F4_HI;
                end
            end else begin
                // ASCII passes through, any other lead becomes a replacement
                if (cnt == 2'd0) begin
                    u0 = i_byte[7] ? REPL_UNIT : {8'd0, i_byte};
                end else begin
                    u1 = i_byte[7] ? REPL_UNIT : {8'd0, i_byte};
                end
                cnt = cnt + 2'd1;
            end
        end

        // flush a sequence still open at end of string
        if (i_eos && n_rem != 2'd0) begin
            if (cnt == 2'd0) begin
                u0 = REPL_UNIT;
            end else begin
                u1 = REPL_UNIT;
            end
            cnt   = cnt + 2'd1;
            n_rem = 2'd0;
            n_acc = '0;
            n_lo  = CONT_LO;
            n_hi  = CONT_HI;
        end
    end

    assign o_take        = i_valid && (i_space || cnt == 2'd0);
    assign o_units.load  = o_take && cnt != 2'd0;
    assign o_units.count = cnt;
    assign o_units.unit0 = u0;
    assign o_units.unit1 = u1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
            r_acc <= '0;
            r_lo  <= CONT_LO;
            r_hi  <= CONT_HI;
        end else if (o_take) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
        end
    end
endmodule

### rtl/w8u16_out_buf.sv
module w8u16_out_buf
    import w8u16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_unit_load i_units,
    output logic       o_space,
    w8u16_out_if.source o_out
);
    logic [1:0]        r_cnt;
    logic [UNIT_W-1:0] r_u0;
    logic [UNIT_W-1:0] r_u1;
    logic              pop;

    assign pop     = (r_cnt != 2'd0) && o_out.ready;
    assign o_space = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_units.load) begin
            r_cnt <= i_units.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_units.load) begin
            r_u0 <= i_units.unit0;
            r_u1 <= i_units.unit1;
        end else if (pop) begin
            // advance the second unit to the head
            r_u0 <= r_u1;
        end
    end

    assign o_out.valid       = r_cnt != 2'd0;
    assign o_out.code_unit   = r_u0;
    assign o_out.last_of_run = r_cnt == 2'd1;
endmodule

### rtl/wtf8_to_utf16_decoder_top.sv
// A byte accepted into the input register is decoded combinationally, and its units are
// loaded into the output buffer register. Throughput: one byte per cycle while the buffer
// has space; the buffer sends one unit per cycle while the sink is ready, so a byte that
// yields a surrogate pair or a replacement plus a unit holds it until both are sent.
// Reset (synchronous, active low) empties the input register and output buffer and
// returns the decoder to no open sequence with default continuation bounds 80-BF.
module wtf8_to_utf16_decoder_top
    import w8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    w8u16_in_if.sink    i_in,
    w8u16_out_if.source o_out
);
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              in_eos;
    logic              take;
    logic              space;
    t_unit_load        units;

    w8u16_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_eos   (in_eos)
    );

    w8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_byte  (in_byte),
        .i_eos   (in_eos),
        .i_space (space),
        .o_take  (take),
        .o_units (units)
    );

    w8u16_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_units (units),
        .o_space (space),
        .o_out   (o_out)
    );
endmodule
